// ===== rtl/lexc_pkg.sv =====
package lexc_pkg;

    // largest set the value store holds
    localparam int MAX_SET = 32;
    localparam int IDX_W   = $clog2(MAX_SET);
    localparam int VAL_W   = 6;
    localparam int CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PICK_COUNT = CFG_IDX_W'(1);

    // reset values of the registers
    localparam logic [VAL_W-1:0] SET_SIZE_RST   = VAL_W'(5);
    localparam logic [VAL_W-1:0] PICK_COUNT_RST = VAL_W'(3);

    // what gets written into the value store
    typedef enum logic [1:0] {
        WR_NONE,
        WR_INC,
        WR_RUN,
        WR_INIT
    } wr_sel_t;

    // which kind of word goes into the output register
    typedef enum logic [1:0] {
        OUT_STORED,
        OUT_INIT,
        OUT_EXHAUSTED,
        OUT_EMPTY
    } out_kind_t;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_CLEAR,
        IDX_TOP,
        IDX_STEP
    } idx_op_t;

    typedef struct packed {
        idx_op_t   idx_op;
        logic      idx_down;
        wr_sel_t   wr_sel;
        logic      out_load;
        out_kind_t out_kind;
        logic      final_flag;
    } lexc_cmd_t;

    typedef struct packed {
        logic cfg_wr;
        logic m_zero;
        logic m_gt_n;
        logic m_eq_n;
        logic idx_zero;
        logic idx_last;
        logic scan_hit;
        logic inc_is_final;
        logic out_free;
    } lexc_status_t;

endpackage

// ===== rtl/lexc_datapath.sv =====
module lexc_datapath
    import lexc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]     cfg_data,
    input  lexc_cmd_t            cmd,
    output lexc_status_t         status,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [VAL_W-1:0]     element,
    output logic                 element_last,
    output logic                 final_combination,
    output logic                 exhausted
);

    logic [VAL_W-1:0] set_size_reg;
    logic [VAL_W-1:0] pick_count_reg;
    logic [VAL_W-1:0] n_eff;
    logic [VAL_W-1:0] m_eff;
    logic [IDX_W-1:0] m_last;

    logic [VAL_W-1:0] vals_reg [MAX_SET];
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [VAL_W-1:0] run_reg;

    logic [VAL_W-1:0] cur_val;
    logic [VAL_W-1:0] cur_inc;
    logic [VAL_W-1:0] idx_plus1;
    logic [VAL_W-1:0] wr_data;
    logic [VAL_W:0]   base;
    logic [VAL_W:0]   limit;

    logic             out_valid_reg;
    logic [VAL_W-1:0] element_reg;
    logic             last_reg;
    logic             final_reg;
    logic             exh_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_size_reg   <= SET_SIZE_RST;
            pick_count_reg <= PICK_COUNT_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_SET_SIZE)
                set_size_reg <= cfg_data;
            else if (cfg_index == REG_PICK_COUNT)
                pick_count_reg <= cfg_data;
        end
    end

    // clamp n and m to the store depth
    assign n_eff  = (set_size_reg > VAL_W'(MAX_SET)) ? VAL_W'(MAX_SET) : set_size_reg;
    assign m_eff  = (pick_count_reg > VAL_W'(MAX_SET)) ? VAL_W'(MAX_SET) : pick_count_reg;
    assign m_last = IDX_W'(m_eff - VAL_W'(1));

    // current entry and the largest value allowed there
    assign cur_val   = vals_reg[idx_reg];
    assign cur_inc   = cur_val + VAL_W'(1);
    assign idx_plus1 = VAL_W'(idx_reg) + VAL_W'(1);
    assign base      = {1'b0, n_eff} - {1'b0, m_eff} + (VAL_W+1)'(1);
    assign limit     = base + (VAL_W+1)'(idx_reg);

    always_comb
    begin
        status.cfg_wr       = cfg_valid && ((cfg_index == REG_SET_SIZE) ||
                                            (cfg_index == REG_PICK_COUNT));
        status.m_zero       = (m_eff == '0);
        status.m_gt_n       = (m_eff > n_eff);
        status.m_eq_n       = (m_eff == n_eff);
        status.idx_zero     = (idx_reg == '0);
        status.idx_last     = (idx_reg == m_last);
        status.scan_hit     = ({1'b0, cur_val} < limit);
        status.inc_is_final = (idx_reg == '0) && ({1'b0, cur_inc} == base);
        status.out_free     = !out_valid_reg || out_ready;
    end

    // position counter
    always_comb
    begin
        unique case (cmd.idx_op)
            IDX_HOLD:  idx_next = idx_reg;
            IDX_CLEAR: idx_next = '0;
            IDX_TOP:   idx_next = m_last;
            IDX_STEP:  idx_next = cmd.idx_down ? idx_reg - IDX_W'(1)
                                               : idx_reg + IDX_W'(1);
            default:   idx_next = idx_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else
            idx_reg <= idx_next;
    end

    // value store write data
    always_comb
    begin
        unique case (cmd.wr_sel)
            WR_INC:  wr_data = cur_inc;
            WR_RUN:  wr_data = run_reg + VAL_W'(1);
            WR_INIT: wr_data = idx_plus1;
            default: wr_data = cur_val;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_sel != WR_NONE)
        begin
            vals_reg[idx_reg] <= wr_data;
            run_reg           <= wr_data;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            unique case (cmd.out_kind)
                OUT_STORED:
                begin
                    element_reg <= cur_val;
                    last_reg    <= status.idx_last;
                    final_reg   <= cmd.final_flag;
                    exh_reg     <= 1'b0;
                end
                OUT_INIT:
                begin
                    element_reg <= idx_plus1;
                    last_reg    <= status.idx_last;
                    final_reg   <= cmd.final_flag;
                    exh_reg     <= 1'b0;
                end
                OUT_EXHAUSTED:
                begin
                    element_reg <= '0;
                    last_reg    <= 1'b1;
                    final_reg   <= 1'b0;
                    exh_reg     <= 1'b1;
                end
                default:
                begin
                    element_reg <= '0;
                    last_reg    <= 1'b1;
                    final_reg   <= 1'b1;
                    exh_reg     <= 1'b0;
                end
            endcase
        end
    end

    assign out_valid         = out_valid_reg;
    assign element           = element_reg;
    assign element_last      = last_reg;
    assign final_combination = final_reg;
    assign exhausted         = exh_reg;

endmodule

// ===== rtl/lexc_ctrl.sv =====
module lexc_ctrl
    import lexc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         restart,
    input  lexc_status_t status,
    output lexc_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FILL,
        S_INIT,
        S_EMIT,
        S_EXH,
        S_EMPTY
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   started_reg;
    logic   started_next;
    logic   finished_reg;
    logic   finished_next;
    logic   final_reg;
    logic   final_next;

    // requests wait while a register word is written
    assign in_ready = (state_reg == S_IDLE) && !status.cfg_wr;

    // sequencing and command decode
    always_comb
    begin
        state_next    = state_reg;
        started_next  = started_reg;
        finished_next = finished_reg;
        final_next    = final_reg;
        cmd.idx_op     = IDX_HOLD;
        cmd.idx_down   = 1'b0;
        cmd.wr_sel     = WR_NONE;
        cmd.out_load   = 1'b0;
        cmd.out_kind   = OUT_STORED;
        cmd.final_flag = final_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (status.cfg_wr)
                begin
                    started_next  = 1'b0;
                    finished_next = 1'b0;
                end
                else if (in_valid)
                begin
                    priority if (restart || !started_reg)
                    begin
                        started_next  = 1'b1;
                        finished_next = 1'b0;
                        if (status.m_gt_n)
                            state_next = S_EXH;
                        else if (status.m_zero)
                            state_next = S_EMPTY;
                        else
                        begin
                            final_next = status.m_eq_n;
                            cmd.idx_op = IDX_CLEAR;
                            state_next = S_INIT;
                        end
                    end
                    else if (finished_reg || status.m_gt_n || status.m_zero)
                        state_next = S_EXH;
                    else
                    begin
                        cmd.idx_op = IDX_TOP;
                        state_next = S_SCAN;
                    end
                end
            end
            // rightmost position that can still grow
            S_SCAN:
            begin
                priority if (status.scan_hit)
                begin
                    cmd.wr_sel = WR_INC;
                    final_next = status.inc_is_final;
                    if (status.idx_last)
                    begin
                        cmd.idx_op = IDX_CLEAR;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        cmd.idx_op = IDX_STEP;
                        state_next = S_FILL;
                    end
                end
                else if (status.idx_zero)
                    state_next = S_EXH;
                else
                begin
                    cmd.idx_op   = IDX_STEP;
                    cmd.idx_down = 1'b1;
                end
            end
            // consecutive refill after the grown position
            S_FILL:
            begin
                cmd.wr_sel = WR_RUN;
                if (status.idx_last)
                begin
                    cmd.idx_op = IDX_CLEAR;
                    state_next = S_EMIT;
                end
                else
                    cmd.idx_op = IDX_STEP;
            end
            // first combination, written and sent together
            S_INIT:
            begin
                if (status.out_free)
                begin
                    cmd.wr_sel   = WR_INIT;
                    cmd.out_load = 1'b1;
                    cmd.out_kind = OUT_INIT;
                    if (status.idx_last)
                    begin
                        finished_next = final_reg;
                        state_next    = S_IDLE;
                    end
                    else
                        cmd.idx_op = IDX_STEP;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = OUT_STORED;
                    if (status.idx_last)
                    begin
                        finished_next = final_reg;
                        state_next    = S_IDLE;
                    end
                    else
                        cmd.idx_op = IDX_STEP;
                end
            end
            S_EXH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_kind  = OUT_EXHAUSTED;
                    finished_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_EMPTY:
            begin
                if (status.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_kind  = OUT_EMPTY;
                    finished_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            started_reg  <= 1'b0;
            finished_reg <= 1'b0;
            final_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            started_reg  <= started_next;
            finished_reg <= finished_next;
            final_reg    <= final_next;
        end
    end

endmodule

// ===== rtl/lexicographic_combination_generator.sv =====
// the first element word is loaded into the output register from S_INIT once a restart
//   request is taken, and from S_EMIT after a next request, once S_SCAN has scanned s
//   positions and S_FILL has refilled f; a new request is taken only in S_IDLE, after
//   the last word of the one before is loaded, a pace set by the serial scan and refill
//   of the value store and the one-word output register
// reset: rst_n clears control state, n = 5, m = 3; the value store is not cleared
module lexicographic_combination_generator
    import lexc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 restart,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [VAL_W-1:0]     element,
    output logic                 element_last,
    output logic                 final_combination,
    output logic                 exhausted
);

    lexc_cmd_t    cmd;
    lexc_status_t status;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    lexc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .restart  (restart),
        .status   (status),
        .cmd      (cmd)
    );

    lexc_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .cmd               (cmd),
        .status            (status),
        .out_ready         (out_ready),
        .out_valid         (out_valid),
        .element           (element),
        .element_last      (element_last),
        .final_combination (final_combination),
        .exhausted         (exhausted)
    );

endmodule

// ===== tb/tb_lexicographic_combination_generator.sv =====
`timescale 1ns / 1ps

module tb_lexicographic_combination_generator;
    import lexc_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_REQS = 100;
    localparam int IDLE_PCT    = 24;
    localparam int TAIL_CYCLES = 80;

    // indexes past the register list, writes to them must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

    typedef struct packed {
        logic [VAL_W-1:0] elem;
        logic             last_flag;
        logic             final_flag;
        logic             exh_flag;
    } combo_word_t;

    // predicts the words of each request and checks them in order
    class combo_scoreboard;
        combo_word_t      pending_words[$];
        int               mismatches;
        logic [VAL_W-1:0] reg_n;
        logic [VAL_W-1:0] reg_m;
        int               subset[MAX_SET];
        bit               started;
        bit               finished;

        function new();
            mismatches = 0;
            reg_n      = SET_SIZE_RST;
            reg_m      = PICK_COUNT_RST;
            started    = 0;
            finished   = 0;
            foreach (subset[i]) subset[i] = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
            case (idx)
                REG_SET_SIZE:   reg_n = data;
                REG_PICK_COUNT: reg_m = data;
                default:        return;
            endcase
            started  = 0;
            finished = 0;
        endfunction

        function void push_word(int e, bit l, bit f, bit x);
            combo_word_t w;
            w.elem       = VAL_W'(e);
            w.last_flag  = l;
            w.final_flag = f;
            w.exh_flag   = x;
            pending_words = {pending_words, w};
        endfunction

        function void push_exhausted();
            finished = 1;
            push_word(0, 1, 0, 1);
        endfunction

        // advance the current subset and queue the words it produces
        function void note_request(bit rs);
            int  n;
            int  m;
            int  pos;
            bit  found;
            bit  is_last;
            n = (reg_n > MAX_SET) ? MAX_SET : int'(reg_n);
            m = (reg_m > MAX_SET) ? MAX_SET : int'(reg_m);
            if (rs || !started) begin
                started  = 1;
                finished = 0;
                if (m > n) begin
                    push_exhausted();
                    return;
                end
                for (int i = 0; i < m; i++) subset[i] = i + 1;
            end
            else begin
                if (finished || m > n) begin
                    push_exhausted();
                    return;
                end
                found = 0;
                pos   = 0;
                // rightmost position still below its ceiling
                for (int i = m; i > 0; i--) begin
                    if (!found && subset[i-1] < n - m + i) begin
                        pos   = i - 1;
                        found = 1;
                    end
                end
                if (!found) begin
                    push_exhausted();
                    return;
                end
                subset[pos] = subset[pos] + 1;
                for (int i = pos + 1; i < m; i++) subset[i] = subset[i-1] + 1;
            end
            // empty subset
            if (m == 0) begin
                finished = 1;
                push_word(0, 1, 1, 0);
                return;
            end
            is_last  = (subset[0] == n - m + 1);
            finished = is_last;
            for (int i = 0; i < m; i++) push_word(subset[i], (i + 1 == m), is_last, 0);
        endfunction

        function void compare_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_word(logic [VAL_W-1:0] e, logic l, logic f, logic x);
            combo_word_t want;
            if (pending_words.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word, expected none, actual %0d/%b/%b/%b",
                         $time, e, l, f, x);
                return;
            end
            want = pending_words.pop_front();
            compare_field("element", want.elem, e);
            compare_field("element_last", VAL_W'(want.last_flag), VAL_W'(l));
            compare_field("final_combination", VAL_W'(want.final_flag), VAL_W'(f));
            compare_field("exhausted", VAL_W'(want.exh_flag), VAL_W'(x));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [VAL_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic                 restart;
    logic                 out_valid;
    logic                 out_ready;
    logic [VAL_W-1:0]     element;
    logic                 element_last;
    logic                 final_combination;
    logic                 exhausted;

    combo_scoreboard sb;
    bit              steady;
    int              cycles = 0;

    lexicographic_combination_generator dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .restart           (restart),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .element           (element),
        .element_last      (element_last),
        .final_combination (final_combination),
        .exhausted         (exhausted)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver backpressure
    always @(posedge clk)
    begin
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_word(element, element_last, final_combination, exhausted);
    end

    // one request word, with a random gap in front
    task automatic send_request(input bit rs);
        if (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
        end
        in_valid <= 1'b1;
        restart  <= rs;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_request(rs);
    endtask

    // hold the sender until every queued word has come out
    task automatic drain();
        if (in_valid)
            in_valid <= 1'b0;
        while (sb.pending_words.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic configure(input logic [VAL_W-1:0] n_val, input logic [VAL_W-1:0] m_val);
        drain();
        write_reg(REG_SET_SIZE, n_val);
        write_reg(REG_PICK_COUNT, m_val);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_spare(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        drain();
        write_reg(idx, data);
        cfg_valid <= 1'b0;
    endtask

    // stimulus
    initial
    begin
        int random_reqs;
        int phase;
        int pick;
        int n_eff;
        int reqs;
        logic [VAL_W-1:0] n_val;
        logic [VAL_W-1:0] m_val;

        sb        = new();
        steady    = 0;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        restart   = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset registers: first request without restart, walk to the end
        for (int i = 0; i < 11; i++) send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        // spare index leaves the enumeration alone
        write_spare(REG_SPARE_B, 6'h3f);
        send_request(1'b0);

        // empty subset
        configure(6'd4, 6'd0);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);

        // more picks than values
        configure(6'd2, 6'd3);
        send_request(1'b0);
        send_request(1'b1);

        // oversized registers clamp to the full set
        configure(6'h3f, 6'h3f);
        send_request(1'b0);
        send_request(1'b0);

        // widest set, single picks, then the smallest set
        configure(6'd32, 6'd1);
        send_request(1'b1);
        send_request(1'b0);
        configure(6'd1, 6'd1);
        send_request(1'b0);
        send_request(1'b0);

        // random phases, each under a fresh setting
        random_reqs = 0;
        phase       = 0;
        while (random_reqs < RANDOM_REQS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 8)
                n_val = VAL_W'($urandom_range(1, 8));
            else if (pick == 8)
                n_val = VAL_W'($urandom_range(9, 32));
            else
                n_val = VAL_W'($urandom_range(33, 63));
            n_eff = (n_val > MAX_SET) ? MAX_SET : int'(n_val);
            pick = $urandom_range(0, 9);
            if (pick == 0)
                m_val = VAL_W'($urandom_range(0, 63));
            else if (n_eff <= 8)
                m_val = VAL_W'($urandom_range(0, n_eff));
            else if (pick < 6)
                m_val = VAL_W'($urandom_range(1, 3));
            else
                m_val = VAL_W'(n_eff - $urandom_range(0, 2));

            drain();
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                          VAL_W'($urandom_range(0, 63)));
            if ($urandom_range(0, 1))
            begin
                write_reg(REG_SET_SIZE, n_val);
                write_reg(REG_PICK_COUNT, m_val);
            end
            else
            begin
                write_reg(REG_PICK_COUNT, m_val);
                write_reg(REG_SET_SIZE, n_val);
            end
            cfg_valid <= 1'b0;

            // one long phase with no idling on either side
            steady = (phase == 2);
            reqs   = steady ? 25 : $urandom_range(8, 20);
            for (int i = 0; i < reqs; i++)
            begin
                send_request($urandom_range(0, 99) < 8);
                random_reqs++;
                if (!steady && $urandom_range(0, 19) == 0)
                    drain();
            end
            steady = 0;
            phase++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_words.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lexc_pkg.sv
rtl/lexc_datapath.sv
rtl/lexc_ctrl.sv
rtl/lexicographic_combination_generator.sv
tb/tb_lexicographic_combination_generator.sv
